/* rtl/gkem_pkg.sv */
// Shared types and constants for the gamepad to keypad event mapper.
`timescale 1ns / 1ps

package gkem_pkg;

	localparam int KEY_SLOTS_DEF = 16;
	localparam int KEY_W         = 5;
	localparam int NUM_KEYS      = 19;

	localparam logic [KEY_W-1:0] K_UP     = 5'd0;
	localparam logic [KEY_W-1:0] K_DOWN   = 5'd1;
	localparam logic [KEY_W-1:0] K_LEFT   = 5'd2;
	localparam logic [KEY_W-1:0] K_RIGHT  = 5'd3;
	localparam logic [KEY_W-1:0] K_SELECT = 5'd4;
	localparam logic [KEY_W-1:0] K_SOFT1  = 5'd5;
	localparam logic [KEY_W-1:0] K_SOFT2  = 5'd6;
	localparam logic [KEY_W-1:0] K_DIGIT0 = 5'd7;
	localparam logic [KEY_W-1:0] K_STAR   = 5'd17;
	localparam logic [KEY_W-1:0] K_POUND  = 5'd18;

	localparam logic [1:0] REG_LAYOUT  = 2'd0;
	localparam logic [1:0] REG_AXIS_ON = 2'd1;
	localparam logic [1:0] REG_AXIS_OFF = 2'd2;

	localparam logic       LAYOUT_RST  = 1'b1;
	localparam logic [6:0] AXIS_ON_RST  = 7'd56;
	localparam logic [6:0] AXIS_OFF_RST = 7'd40;

	localparam logic [7:0] AXIS_CENTER = 8'd128;
	localparam logic [9:0] DIAG_NUM    = 10'd1000;
	localparam logic [9:0] DIAG_DEN    = 10'd414;

	// last candidate index of each layout
	localparam logic [4:0] CAND_LAST_SIMPLE = 5'd6;
	localparam logic [4:0] CAND_LAST_PHONE  = 5'd20;

	localparam logic [2:0] MSTEP_LAST = 3'd7;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_DIR,
		ST_BUILD,
		ST_REL,
		ST_PRS,
		ST_FLUSH
	} state_t;

endpackage

/* rtl/gamepad_to_keypad_event_mapper_unit.sv */
// Top level: gamepad poll to keypad press/release event sequencer.
`timescale 1ns / 1ps
// Sequence: a poll runs through accept, multiply, decide and build steps, then release steps
//   over the previous key set, press steps over the current key set and a flush step;
//   out_ready can stall the release, press and flush steps.
// Throughput: one poll at a time; in_ready is high only while idle.
// Reset (arst_n low): latches, sector, key-set count and first-poll flag clear,
//   registers return to phone layout, on offset 56, off offset 40.

module gamepad_to_keypad_event_mapper_unit #(
	parameter int KEY_SLOTS = gkem_pkg::KEY_SLOTS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_wr_en,
	input  logic [1:0] cfg_index,
	input  logic [6:0] cfg_wdata,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [14:0] buttons,
	input  logic [7:0] left_x,
	input  logic [7:0] left_y,
	input  logic [7:0] right_x,
	input  logic [7:0] right_y,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [4:0] key_code,
	output logic       pressed,
	output logic       last
);

	localparam int IW = (KEY_SLOTS > 1) ? $clog2(KEY_SLOTS) : 1;
	localparam int CW = $clog2(KEY_SLOTS + 1);
	localparam int NK = gkem_pkg::NUM_KEYS;
	localparam logic [CW-1:0] SLOTS_C = CW'(KEY_SLOTS);

	// configuration registers
	logic       layout_q;
	logic [6:0] on_q, off_q;

	// captured poll
	logic [14:0] btn_q;
	logic [7:0]  lx_q, ly_q, rx_q, ry_q;

	// sequencer
	gkem_pkg::state_t state_q, state_d;
	logic [2:0] mstep_q;
	logic [4:0] cand_q;
	logic [CW-1:0] ri_q;

	// shared multiplier results
	logic [17:0] prod_q [8];

	// persistent state
	logic [3:0] lat_q;
	logic       sec_v_q;
	logic [4:0] sec_key_q;
	logic       have_prev_q;
	logic [CW-1:0] prev_n_q;
	logic [NK-1:0] prev_mask_q;
	logic [4:0]    prev_keys [KEY_SLOTS];

	// current key set
	logic [CW-1:0] cur_n_q;
	logic [NK-1:0] cur_mask_q;
	logic [4:0]    cur_keys [KEY_SLOTS];
	logic [3:0]    dir_q;

	// pending event (held back until the next event or the flush so its last flag is known) and output register
	logic       pend_v_q, pend_p_q;
	logic [4:0] pend_key_q;
	logic       out_v_q, out_p_q, out_last_q;
	logic [4:0] out_key_q;

	// ---------------------------------------------------------------------
	// Shared multiplier: one 8x10 product per cycle during ST_MUL.
	// Steps: ax^2, ay^2, on^2, off^2, ax*1000, ay*414, ay*1000, ax*414.
	// ---------------------------------------------------------------------
	logic [7:0] ax, ay, mul_a;
	logic [9:0] mul_b;
	logic [17:0] mul_p;

	assign ax = (rx_q >= gkem_pkg::AXIS_CENTER) ? (rx_q - gkem_pkg::AXIS_CENTER)
		: (gkem_pkg::AXIS_CENTER - rx_q);
	assign ay = (ry_q >= gkem_pkg::AXIS_CENTER) ? (ry_q - gkem_pkg::AXIS_CENTER)
		: (gkem_pkg::AXIS_CENTER - ry_q);

	always_comb begin
		unique case (mstep_q)
			3'd0: begin mul_a = ax;          mul_b = {2'b0, ax}; end
			3'd1: begin mul_a = ay;          mul_b = {2'b0, ay}; end
			3'd2: begin mul_a = {1'b0, on_q}; mul_b = {3'b0, on_q}; end
			3'd3: begin mul_a = {1'b0, off_q}; mul_b = {3'b0, off_q}; end
			3'd4: begin mul_a = ax;          mul_b = gkem_pkg::DIAG_NUM; end
			3'd5: begin mul_a = ay;          mul_b = gkem_pkg::DIAG_DEN; end
			3'd6: begin mul_a = ay;          mul_b = gkem_pkg::DIAG_NUM; end
			default: begin mul_a = ax;       mul_b = gkem_pkg::DIAG_DEN; end
		endcase
	end

	assign mul_p = {10'b0, mul_a} * {8'b0, mul_b};

	// ---------------------------------------------------------------------
	// Direction latches and sector decision, evaluated in ST_DIR.
	// ---------------------------------------------------------------------
	function automatic logic latch_next(input logic lat, input logic signed [9:0] ofs,
		input logic [6:0] on, input logic [6:0] off);
		logic signed [9:0] son, soff;
		son  = $signed({3'b0, on});
		soff = $signed({3'b0, off});
		latch_next = lat ? !(ofs < soff) : (ofs > son);
	endfunction

	logic signed [9:0] ofs_up, ofs_dn, ofs_lf, ofs_rt;
	logic [3:0] lat_d;
	logic [18:0] mag;
	logic diag, dx_pos, north_pos;
	logic [3:0] digit;
	logic [4:0] oct_key;
	logic sec_v_d;
	logic [4:0] sec_key_d;

	assign ofs_up = $signed({2'b0, gkem_pkg::AXIS_CENTER}) - $signed({2'b0, ly_q});
	assign ofs_dn = -ofs_up;
	assign ofs_lf = $signed({2'b0, gkem_pkg::AXIS_CENTER}) - $signed({2'b0, lx_q});
	assign ofs_rt = -ofs_lf;

	assign lat_d[0] = latch_next(lat_q[0], ofs_up, on_q, off_q);
	assign lat_d[1] = latch_next(lat_q[1], ofs_dn, on_q, off_q);
	assign lat_d[2] = latch_next(lat_q[2], ofs_lf, on_q, off_q);
	assign lat_d[3] = latch_next(lat_q[3], ofs_rt, on_q, off_q);

	assign mag       = {1'b0, prod_q[0]} + {1'b0, prod_q[1]};
	assign diag      = (prod_q[4] > prod_q[5]) && (prod_q[6] > prod_q[7]);
	assign dx_pos    = rx_q > gkem_pkg::AXIS_CENTER;
	assign north_pos = ry_q < gkem_pkg::AXIS_CENTER;

	always_comb begin
		if (diag) begin
			if (north_pos) digit = dx_pos ? 4'd3 : 4'd1;
			else           digit = dx_pos ? 4'd9 : 4'd7;
		end else if (ax > ay) begin
			digit = dx_pos ? 4'd6 : 4'd4;
		end else begin
			digit = north_pos ? 4'd2 : 4'd8;
		end
	end

	assign oct_key = gkem_pkg::K_DIGIT0 + {1'b0, digit};

	always_comb begin
		sec_v_d   = sec_v_q;
		sec_key_d = sec_key_q;
		if (!sec_v_q) begin
			if (mag > {1'b0, prod_q[2]}) begin
				sec_v_d   = 1'b1;
				sec_key_d = oct_key;
			end
		end else if (mag < {1'b0, prod_q[3]}) begin
			sec_v_d   = 1'b0;
			sec_key_d = gkem_pkg::K_UP;
		end else begin
			sec_key_d = oct_key;
		end
	end

	// ---------------------------------------------------------------------
	// Candidate keys, one per build step, in layout order.
	// ---------------------------------------------------------------------
	logic       cand_v;
	logic [4:0] cand_key;
	logic [4:0] cand_last;

	assign cand_last = layout_q ? gkem_pkg::CAND_LAST_PHONE : gkem_pkg::CAND_LAST_SIMPLE;

	always_comb begin
		cand_v   = 1'b0;
		cand_key = gkem_pkg::K_UP;
		if (!layout_q) begin
			unique case (cand_q)
				5'd0: begin cand_v = dir_q[0]; cand_key = gkem_pkg::K_UP; end
				5'd1: begin cand_v = dir_q[1]; cand_key = gkem_pkg::K_DOWN; end
				5'd2: begin cand_v = dir_q[2]; cand_key = gkem_pkg::K_LEFT; end
				5'd3: begin cand_v = dir_q[3]; cand_key = gkem_pkg::K_RIGHT; end
				5'd4: begin cand_v = btn_q[4]; cand_key = gkem_pkg::K_SELECT; end
				5'd5: begin cand_v = btn_q[8]; cand_key = gkem_pkg::K_SOFT1; end
				5'd6: begin cand_v = btn_q[9]; cand_key = gkem_pkg::K_SOFT2; end
				default: ;
			endcase
		end else begin
			unique case (cand_q)
				5'd0:  begin cand_v = dir_q[0]; cand_key = gkem_pkg::K_UP; end
				5'd1:  begin cand_v = dir_q[0]; cand_key = gkem_pkg::K_DIGIT0 + 5'd2; end
				5'd2:  begin cand_v = dir_q[1]; cand_key = gkem_pkg::K_DOWN; end
				5'd3:  begin cand_v = dir_q[1]; cand_key = gkem_pkg::K_DIGIT0 + 5'd8; end
				5'd4:  begin cand_v = dir_q[2]; cand_key = gkem_pkg::K_LEFT; end
				5'd5:  begin cand_v = dir_q[2]; cand_key = gkem_pkg::K_DIGIT0 + 5'd4; end
				5'd6:  begin cand_v = dir_q[3]; cand_key = gkem_pkg::K_RIGHT; end
				5'd7:  begin cand_v = dir_q[3]; cand_key = gkem_pkg::K_DIGIT0 + 5'd6; end
				5'd8:  begin cand_v = btn_q[4]; cand_key = gkem_pkg::K_SELECT; end
				5'd9:  begin cand_v = btn_q[4]; cand_key = gkem_pkg::K_DIGIT0 + 5'd5; end
				5'd10: begin cand_v = btn_q[5]; cand_key = gkem_pkg::K_STAR; end
				5'd11: begin cand_v = btn_q[6]; cand_key = gkem_pkg::K_DIGIT0; end
				5'd12: begin cand_v = btn_q[7]; cand_key = gkem_pkg::K_POUND; end
				5'd13: begin cand_v = btn_q[8]; cand_key = gkem_pkg::K_DIGIT0 + 5'd1; end
				5'd14: begin cand_v = btn_q[9]; cand_key = gkem_pkg::K_DIGIT0 + 5'd3; end
				5'd15: begin cand_v = btn_q[10]; cand_key = gkem_pkg::K_DIGIT0 + 5'd7; end
				5'd16: begin cand_v = btn_q[11]; cand_key = gkem_pkg::K_DIGIT0 + 5'd9; end
				5'd17: begin cand_v = btn_q[12]; cand_key = gkem_pkg::K_SOFT1; end
				5'd18: begin cand_v = btn_q[13]; cand_key = gkem_pkg::K_SOFT2; end
				5'd19: begin cand_v = sec_v_q;  cand_key = sec_key_q; end
				5'd20: begin cand_v = btn_q[14]; cand_key = gkem_pkg::K_DIGIT0 + 5'd5; end
				default: ;
			endcase
		end
	end

	logic cand_add;
	assign cand_add = cand_v && !cur_mask_q[cand_key] && (cur_n_q < SLOTS_C);

	// ---------------------------------------------------------------------
	// Control: next state and step outputs.
	// ---------------------------------------------------------------------
	logic       out_free, ev_v, ev_p, hold, rel_done, prs_done;
	logic       ev_take, flush_out;
	logic [4:0] ev_key, rel_key, prs_key;

	assign out_free = !out_v_q || out_ready;
	assign rel_key  = prev_keys[ri_q[IW-1:0]];
	assign prs_key  = cur_keys[ri_q[IW-1:0]];
	assign rel_done = !have_prev_q || (ri_q == prev_n_q);
	assign prs_done = ri_q == cur_n_q;

	always_comb begin
		ev_v   = 1'b0;
		ev_p   = 1'b0;
		ev_key = rel_key;
		unique case (state_q)
			gkem_pkg::ST_REL: begin
				ev_v = !rel_done && !cur_mask_q[rel_key];
			end
			gkem_pkg::ST_PRS: begin
				ev_v   = !prs_done && have_prev_q && !prev_mask_q[prs_key];
				ev_p   = 1'b1;
				ev_key = prs_key;
			end
			default: ;
		endcase
		in_ready = state_q == gkem_pkg::ST_IDLE;
		// stall a step whose event would overwrite a pending one that cannot move out
		hold = ev_v && pend_v_q && !out_free;
		// take the step's event into the pending slot
		ev_take = ev_v && !hold;
		// move the final pending event out, marked last
		flush_out = (state_q == gkem_pkg::ST_FLUSH) && pend_v_q && out_free;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			gkem_pkg::ST_IDLE:  if (in_valid) state_d = gkem_pkg::ST_MUL;
			gkem_pkg::ST_MUL:   if (mstep_q == gkem_pkg::MSTEP_LAST) state_d = gkem_pkg::ST_DIR;
			gkem_pkg::ST_DIR:   state_d = gkem_pkg::ST_BUILD;
			gkem_pkg::ST_BUILD: if (cand_q == cand_last) state_d = gkem_pkg::ST_REL;
			gkem_pkg::ST_REL:   if (rel_done) state_d = gkem_pkg::ST_PRS;
			gkem_pkg::ST_PRS:   if (prs_done) state_d = gkem_pkg::ST_FLUSH;
			gkem_pkg::ST_FLUSH: if (!pend_v_q || out_free) state_d = gkem_pkg::ST_IDLE;
			default:            state_d = gkem_pkg::ST_IDLE;
		endcase
	end

	// ---------------------------------------------------------------------
	// Registers.
	// ---------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			layout_q <= gkem_pkg::LAYOUT_RST;
			on_q     <= gkem_pkg::AXIS_ON_RST;
			off_q    <= gkem_pkg::AXIS_OFF_RST;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				gkem_pkg::REG_LAYOUT:   layout_q <= cfg_wdata[0];
				gkem_pkg::REG_AXIS_ON:  on_q     <= cfg_wdata;
				gkem_pkg::REG_AXIS_OFF: off_q    <= cfg_wdata;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= gkem_pkg::ST_IDLE;
			mstep_q     <= '0;
			cand_q      <= '0;
			ri_q        <= '0;
			lat_q       <= '0;
			sec_v_q     <= 1'b0;
			sec_key_q   <= gkem_pkg::K_UP;
			have_prev_q <= 1'b0;
			prev_n_q    <= '0;
			prev_mask_q <= '0;
			cur_n_q     <= '0;
			cur_mask_q  <= '0;
			dir_q       <= '0;
			pend_v_q    <= 1'b0;
			out_v_q     <= 1'b0;
		end else begin
			state_q <= state_d;
			unique case (state_q)
				gkem_pkg::ST_IDLE: begin
					mstep_q    <= '0;
					cand_q     <= '0;
					ri_q       <= '0;
					cur_n_q    <= '0;
					cur_mask_q <= '0;
				end
				gkem_pkg::ST_MUL: mstep_q <= mstep_q + 3'd1;
				gkem_pkg::ST_DIR: begin
					lat_q <= lat_d;
					dir_q <= btn_q[3:0] | lat_d;
					if (layout_q) begin
						sec_v_q   <= sec_v_d;
						sec_key_q <= sec_key_d;
					end
				end
				gkem_pkg::ST_BUILD: begin
					cand_q <= cand_q + 5'd1;
					if (cand_add) begin
						cur_mask_q[cand_key] <= 1'b1;
						cur_n_q              <= cur_n_q + 1'b1;
					end
				end
				gkem_pkg::ST_REL: begin
					if (rel_done) ri_q <= '0;
					else if (!hold) ri_q <= ri_q + 1'b1;
				end
				gkem_pkg::ST_PRS: begin
					if (prs_done) begin
						prev_mask_q <= cur_mask_q;
						prev_n_q    <= cur_n_q;
						have_prev_q <= 1'b1;
					end else if (!hold) begin
						ri_q <= ri_q + 1'b1;
					end
				end
				default: ;
			endcase
			// advance the pending event into the output register; only the flush marks it last
			if (flush_out || (ev_take && pend_v_q)) begin
				out_v_q    <= 1'b1;
				out_key_q  <= pend_key_q;
				out_p_q    <= pend_p_q;
				out_last_q <= flush_out;
			end else if (out_ready) begin
				out_v_q <= 1'b0;
			end
			if (flush_out) begin
				pend_v_q <= 1'b0;
			end else if (ev_take) begin
				pend_v_q   <= 1'b1;
				pend_key_q <= ev_key;
				pend_p_q   <= ev_p;
			end
		end
	end

	// payload registers: captured poll, products and key lists
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			btn_q <= buttons;
			lx_q  <= left_x;
			ly_q  <= left_y;
			rx_q  <= right_x;
			ry_q  <= right_y;
		end
		if (state_q == gkem_pkg::ST_MUL) prod_q[mstep_q] <= mul_p;
		if (state_q == gkem_pkg::ST_BUILD && cand_add) cur_keys[cur_n_q[IW-1:0]] <= cand_key;
		if (state_q == gkem_pkg::ST_PRS && !prs_done && !hold)
			prev_keys[ri_q[IW-1:0]] <= prs_key;
	end

	assign out_valid = out_v_q;
	assign key_code  = out_key_q;
	assign pressed   = out_p_q;
	assign last      = out_last_q;

	// ---------------------------------------------------------------------
	// Assertions.
	// ---------------------------------------------------------------------
	a_cur_count: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(cur_mask_q) == int'(cur_n_q))
		else $error("current key mask disagrees with key count");

	a_slots: assert property (@(posedge clk) disable iff (!arst_n)
		(cur_n_q <= SLOTS_C) && (prev_n_q <= SLOTS_C))
		else $error("key set exceeds slot count");

	a_idle_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == gkem_pkg::ST_IDLE) |-> !pend_v_q)
		else $error("event left pending after poll finished");

	a_first_silent: assert property (@(posedge clk) disable iff (!arst_n)
		!have_prev_q |-> !ev_v)
		else $error("event raised on first poll");

endmodule
